@@ rtl/pr80_pkg.sv @@
// PRESENT-80 encryption package: widths, S-box, bit permutation, key schedule step.
// Standalone; used by every module of the block.
package pr80_pkg;

   localparam int unsigned BLOCK_W     = 64;
   localparam int unsigned KEY_W       = 80;
   localparam int unsigned KEY_LOW_W   = 64;
   localparam int unsigned KEY_HIGH_W  = 16;
   localparam int unsigned RC_W        = 5;
   localparam int unsigned ROUND_COUNT = 31;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_ADDR_W  = 4;

   // register index, taken from paddr[3] (8-byte spacing)
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [KEY_W-1:0]   key_type;

   function automatic logic [3:0] sbox(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'hC;
         4'h1: y = 4'h5;
         4'h2: y = 4'h6;
         4'h3: y = 4'hB;
         4'h4: y = 4'h9;
         4'h5: y = 4'h0;
         4'h6: y = 4'hA;
         4'h7: y = 4'hD;
         4'h8: y = 4'h3;
         4'h9: y = 4'hE;
         4'hA: y = 4'hF;
         4'hB: y = 4'h8;
         4'hC: y = 4'h4;
         4'hD: y = 4'h7;
         4'hE: y = 4'h1;
         4'hF: y = 4'h2;
         default: y = 4'h0;
      endcase
      return y;
   endfunction

   function automatic block_type sub_layer(input block_type s);
      block_type r;
      for (int n = 0; n < BLOCK_W / 4; n++) begin
         r[4*n +: 4] = sbox(s[4*n +: 4]);
      end
      return r;
   endfunction

   // bit i moves to i/4 + 16*(i%4)
   function automatic block_type perm_layer(input block_type s);
      block_type r;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[i / 4 + (BLOCK_W / 4) * (i % 4)] = s[i];
      end
      return r;
   endfunction

   // rotate left 61, S-box on top nibble, round counter into bits 19..15
   function automatic key_type key_step(input key_type k, input logic [RC_W-1:0] rc);
      key_type r;
      r = {k[18:0], k[KEY_W-1:19]};
      r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
      r[19:15] = r[19:15] ^ rc;
      return r;
   endfunction

   function automatic block_type round_key(input key_type k);
      return k[KEY_W-1 -: BLOCK_W];
   endfunction

endpackage

@@ rtl/present80_block_encrypt_top.sv @@
// PRESENT-80 block encryption, top level: key registers, 31 round stages, final key add.
// Depends on pr80_pkg, pr80_csr and pr80_round.
//
// Usage:
//  - Load the 80-bit key over the APB-style port: key bits 63..0 at byte address 0,
//    key bits 79..64 at byte address 8 (64-bit data bus, pready always high).
//    Change the key only while no transaction is in flight.
//  - Input: a transaction is taken at each rising edge with start high and busy low.
//    busy never rises, so one block can enter every cycle.
//  - Output: rsp_valid is high for exactly one cycle with rsp_ciphertext; the
//    receiver cannot stall, so results leave in order without backpressure.
//  - Pipeline: 31 round stages each hold one round plus the matching
//    key-schedule step; the output register after them adds the last round key.
//  - Throughput: one block per cycle; each stage carries its own copy of the
//    round key, so blocks in flight never share key state.
//  - Reset (synchronous): clears the key to zero and drops every transaction
//    in flight; the valid bits of all stages clear at once.
module present80_block_encrypt_top (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                start,
   output logic                                busy,
   input  logic [pr80_pkg::BLOCK_W-1:0]        req_plaintext,
   // result channel
   output logic                                rsp_valid,
   output logic [pr80_pkg::BLOCK_W-1:0]        rsp_ciphertext,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pr80_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pr80_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pr80_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   pr80_pkg::key_type   cfg_key;

   // index 0 is the pipeline input, index r the output of round r
   logic                stage_vld   [0:pr80_pkg::ROUND_COUNT];
   pr80_pkg::block_type stage_state [0:pr80_pkg::ROUND_COUNT];
   pr80_pkg::key_type   stage_key   [0:pr80_pkg::ROUND_COUNT];

   logic                rsp_valid_ff, rsp_valid_in;
   pr80_pkg::block_type rsp_text_ff,  rsp_text_in;

   logic                accept;

   pr80_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (cfg_key)
   );

   // fully pipelined: never refuses a transaction
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign stage_vld[0]   = accept;
   assign stage_state[0] = req_plaintext;
   assign stage_key[0]   = cfg_key;

   for (genvar r = 1; r <= pr80_pkg::ROUND_COUNT; r++) begin : g_round
      pr80_round u_round (
         .clock     (clock),
         .reset     (reset),
         .round_cnt (pr80_pkg::RC_W'(r)),
         .vld_in    (stage_vld[r-1]),
         .state_in  (stage_state[r-1]),
         .key_in    (stage_key[r-1]),
         .vld_out   (stage_vld[r]),
         .blk_out   (stage_state[r]),
         .key_out   (stage_key[r])
      );
   end

   // final whitening with the 32nd round key
   assign rsp_valid_in = stage_vld[pr80_pkg::ROUND_COUNT];
   assign rsp_text_in  = stage_state[pr80_pkg::ROUND_COUNT]
                         ^ pr80_pkg::round_key(stage_key[pr80_pkg::ROUND_COUNT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_text_ff <= rsp_text_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_text_ff;

   // every accepted transaction produces a result strobe
   a_fwd_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##32 rsp_valid)
      else $error("accepted transaction did not produce a result after 32 cycles");

   // no result without a matching accept
   a_bwd_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 32))
      else $error("result strobe without an accepted transaction 32 cycles earlier");

   // output register is fed only by the last round stage
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(stage_vld[pr80_pkg::ROUND_COUNT]))
      else $error("result strobe without a valid last round stage");

endmodule

@@ rtl/pr80_csr.sv @@
// PRESENT-80 key registers behind an APB-style port.
// Depends on pr80_pkg.
module pr80_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pr80_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pr80_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pr80_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output pr80_pkg::key_type                   key
);

   logic [pr80_pkg::KEY_LOW_W-1:0]  key_low_ff,  key_low_in;
   logic [pr80_pkg::KEY_HIGH_W-1:0] key_high_ff, key_high_in;
   logic                            wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (wr_en) begin
         case (paddr[3])
            pr80_pkg::REG_KEY_LOW:  key_low_in  = pwdata;
            pr80_pkg::REG_KEY_HIGH: key_high_in = pwdata[pr80_pkg::KEY_HIGH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   // reads off the register grid return zero
   always_comb begin
      prdata = '0;
      if (paddr[2:0] == 3'd0) begin
         case (paddr[3])
            pr80_pkg::REG_KEY_LOW:  prdata = key_low_ff;
            pr80_pkg::REG_KEY_HIGH:
               prdata = {{(pr80_pkg::CSR_DATA_W-pr80_pkg::KEY_HIGH_W){1'b0}}, key_high_ff};
            default: prdata = '0;
         endcase
      end
   end

   assign key = {key_high_ff, key_low_ff};

endmodule

@@ rtl/pr80_round.sv @@
// One PRESENT-80 round as a pipeline stage: round key add, S-box, permutation, key step.
// Depends on pr80_pkg.
module pr80_round (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pr80_pkg::RC_W-1:0]     round_cnt,
   input  logic                          vld_in,
   input  pr80_pkg::block_type           state_in,
   input  pr80_pkg::key_type             key_in,
   output logic                          vld_out,
   output pr80_pkg::block_type           blk_out,
   output pr80_pkg::key_type             key_out
);

   logic                vld_ff,   vld_in_d;
   pr80_pkg::block_type state_ff, state_in_d;
   pr80_pkg::key_type   key_ff,   key_in_d;

   assign vld_in_d   = vld_in;
   assign state_in_d = pr80_pkg::perm_layer(pr80_pkg::sub_layer(
                          state_in ^ pr80_pkg::round_key(key_in)));
   assign key_in_d   = pr80_pkg::key_step(key_in, round_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in_d;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      state_ff <= state_in_d;
      key_ff   <= key_in_d;
   end

   assign vld_out = vld_ff;
   assign blk_out = state_ff;
   assign key_out = key_ff;

endmodule
